>>> rtl/complex_integer_alu_top_defines.svh
// Assertion macros used by the checker file of the complex ALU.
`ifndef COMPLEX_INTEGER_ALU_TOP_DEFINES_SVH
`define COMPLEX_INTEGER_ALU_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define CAI_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define CAI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cai_pkg.sv
// Package of the complex ALU: widths, command codes, pipeline item and helpers.
package cai_pkg;

  // Width of one operand part.
  localparam int PartWidth = 16;
  // Width of a product and of a quotient magnitude.
  localparam int QuotWidth = 2 * PartWidth;
  // Width of a signed sum of two products.
  localparam int SumWidth  = QuotWidth + 1;
  // Width of a result part.
  localparam int ResWidth  = 32;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cai_cmd_e;

  // One beat as it travels down the divider chain.
  typedef struct packed {
    logic                 is_div;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic [SumWidth-1:0]  val_re;
    logic [SumWidth-1:0]  val_im;
    logic [QuotWidth-1:0] rem_re;
    logic [QuotWidth-1:0] rem_im;
    logic [QuotWidth-1:0] den;
  } cai_item_t;

  // Clamp a signed sum into the signed result range.
  function automatic logic [ResWidth-1:0] sat_res(input logic [SumWidth-1:0] v);
    logic signed [63:0] x;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    x  = {{(64 - SumWidth){v[SumWidth-1]}}, v};
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      sat_res = hi[ResWidth-1:0];
    end else if (x < lo) begin
      sat_res = lo[ResWidth-1:0];
    end else begin
      sat_res = x[ResWidth-1:0];
    end
  endfunction

endpackage

>>> rtl/complex_integer_alu_top.sv
// A beat passes the front-end product and combine registers, the divider cells and the back-end output register.
// Throughput: one beat per cycle; the divider is a chain of 2*PartWidth cells,
// one quotient bit each, and every stage stalls only when its successor is full.
// Reset clears every stage valid bit asynchronously; payload registers are not reset.
// Top level of the complex ALU: front end, divider chain, back end.
module complex_integer_alu_top import cai_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [PartWidth-1:0] a_re_i,
  input  logic [PartWidth-1:0] a_im_i,
  input  logic [PartWidth-1:0] b_re_i,
  input  logic [PartWidth-1:0] b_im_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ResWidth-1:0]  res_re_o,
  output logic [ResWidth-1:0]  res_im_o,
  output logic                 div_zero_o
);

  logic      ch_valid [QuotWidth+1];
  logic      ch_ready [QuotWidth+1];
  cai_item_t ch_item  [QuotWidth+1];

  // Operand products and combination.
  cai_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .command_i (command_i),
    .a_re_i    (a_re_i),
    .a_im_i    (a_im_i),
    .b_re_i    (b_re_i),
    .b_im_i    (b_im_i),
    .valid_o   (ch_valid[0]),
    .ready_i   (ch_ready[0]),
    .item_o    (ch_item[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < QuotWidth; k++) begin : g_cell
    cai_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_valid[k]),
      .ready_o (ch_ready[k]),
      .item_i  (ch_item[k]),
      .valid_o (ch_valid[k+1]),
      .ready_i (ch_ready[k+1]),
      .item_o  (ch_item[k+1])
    );
  end

  // Sign fix-up, clamping and output register.
  cai_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (ch_valid[QuotWidth]),
    .ready_o    (ch_ready[QuotWidth]),
    .item_i     (ch_item[QuotWidth]),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .res_re_o   (res_re_o),
    .res_im_o   (res_im_o),
    .div_zero_o (div_zero_o)
  );

endmodule

>>> rtl/cai_front.sv
// Front end: product stage and combine stage that build the beat for the divider chain.
module cai_front import cai_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [1:0]           command_i,
  input  logic [PartWidth-1:0] a_re_i,
  input  logic [PartWidth-1:0] a_im_i,
  input  logic [PartWidth-1:0] b_re_i,
  input  logic [PartWidth-1:0] b_im_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cai_item_t            item_o
);

  logic signed [PartWidth-1:0] ar, ai, br, bi;

  logic                         v1_q;
  logic [1:0]                   cmd_q;
  logic signed [PartWidth:0]    s_re_q, s_im_q;
  logic signed [QuotWidth-1:0]  rr_q, ii_q, ri_q, ir_q, brr_q, bii_q;
  logic                         rdy1;

  logic                         v2_q;
  cai_item_t                    item_q, item_d;
  logic                         rdy2;

  logic signed [SumWidth-1:0]   num_re, num_im, mul_re, mul_im;
  logic [QuotWidth-1:0]         den;

  assign ar = a_re_i;
  assign ai = a_im_i;
  assign br = b_re_i;
  assign bi = b_im_i;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign item_o  = item_q;

  // Stage one control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= valid_i;
    end
  end

  // Stage one: the six products and the add or subtract result.
  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      cmd_q <= command_i;
      if (command_i == CmdSub) begin
        s_re_q <= (PartWidth + 1)'(ar) - (PartWidth + 1)'(br);
        s_im_q <= (PartWidth + 1)'(ai) - (PartWidth + 1)'(bi);
      end else begin
        s_re_q <= (PartWidth + 1)'(ar) + (PartWidth + 1)'(br);
        s_im_q <= (PartWidth + 1)'(ai) + (PartWidth + 1)'(bi);
      end
      rr_q  <= QuotWidth'(ar) * QuotWidth'(br);
      ii_q  <= QuotWidth'(ai) * QuotWidth'(bi);
      ri_q  <= QuotWidth'(ar) * QuotWidth'(bi);
      ir_q  <= QuotWidth'(ai) * QuotWidth'(br);
      brr_q <= QuotWidth'(br) * QuotWidth'(br);
      bii_q <= QuotWidth'(bi) * QuotWidth'(bi);
    end
  end

  // Stage two: sums of products, divisor and sign split for division.
  always_comb begin
    num_re = SumWidth'(rr_q) + SumWidth'(ii_q);
    num_im = SumWidth'(ir_q) - SumWidth'(ri_q);
    mul_re = SumWidth'(rr_q) - SumWidth'(ii_q);
    mul_im = SumWidth'(ri_q) + SumWidth'(ir_q);
    den    = brr_q[QuotWidth-1:0] + bii_q[QuotWidth-1:0];

    item_d        = '0;
    item_d.den    = den;
    item_d.is_div = (cmd_q == CmdDiv);
    unique case (cmd_q) inside
      CmdAdd, CmdSub: begin
        item_d.val_re = SumWidth'(s_re_q);
        item_d.val_im = SumWidth'(s_im_q);
      end
      CmdMul: begin
        item_d.val_re = mul_re;
        item_d.val_im = mul_im;
      end
      default: begin
        item_d.dz     = (den == '0);
        item_d.neg_re = num_re[SumWidth-1];
        item_d.neg_im = num_im[SumWidth-1];
        item_d.val_re = num_re[SumWidth-1] ? -num_re : num_re;
        item_d.val_im = num_im[SumWidth-1] ? -num_im : num_im;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      item_q <= item_d;
    end
  end

endmodule

>>> rtl/cai_div_cell.sv
// Divider cell: one restoring quotient bit for both parts of a beat.
module cai_div_cell import cai_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cai_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cai_item_t item_o
);

  logic                 valid_q;
  cai_item_t            item_q, item_d;
  logic [QuotWidth:0]   t_re, t_im;
  logic                 q_re, q_im;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // Shift the next dividend bit into each remainder and try the divisor.
  always_comb begin
    item_d = item_i;
    t_re   = {item_i.rem_re, item_i.val_re[QuotWidth-1]};
    t_im   = {item_i.rem_im, item_i.val_im[QuotWidth-1]};
    q_re   = (t_re >= {1'b0, item_i.den});
    q_im   = (t_im >= {1'b0, item_i.den});
    if (item_i.is_div) begin
      item_d.rem_re = q_re ? QuotWidth'(t_re - {1'b0, item_i.den}) : t_re[QuotWidth-1:0];
      item_d.rem_im = q_im ? QuotWidth'(t_im - {1'b0, item_i.den}) : t_im[QuotWidth-1:0];
      item_d.val_re = {1'b0, item_i.val_re[QuotWidth-2:0], q_re};
      item_d.val_im = {1'b0, item_i.val_im[QuotWidth-2:0], q_im};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

>>> rtl/cai_back.sv
// Back end: quotient sign, clamping and the output register.
module cai_back import cai_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  cai_item_t           item_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [ResWidth-1:0] res_re_o,
  output logic [ResWidth-1:0] res_im_o,
  output logic                div_zero_o
);

  logic                valid_q;
  logic [ResWidth-1:0] re_q, im_q, re_d, im_d;
  logic                dz_q;
  logic [SumWidth-1:0] sv_re, sv_im;

  assign ready_o    = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign res_re_o   = re_q;
  assign res_im_o   = im_q;
  assign div_zero_o = dz_q;

  // Give the quotient its sign back, then clamp to the result range; a divide-by-zero beat gives zero parts.
  always_comb begin
    sv_re = item_i.val_re;
    sv_im = item_i.val_im;
    if (item_i.is_div) begin
      sv_re = item_i.neg_re ? -item_i.val_re : item_i.val_re;
      sv_im = item_i.neg_im ? -item_i.val_im : item_i.val_im;
    end
    re_d = item_i.dz ? '0 : sat_res(sv_re);
    im_d = item_i.dz ? '0 : sat_res(sv_im);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      re_q <= re_d;
      im_q <= im_d;
      dz_q <= item_i.dz;
    end
  end

endmodule

>>> rtl/cai_checker.sv
// Port-level checker of the complex ALU and its bind to the top level.
`include "complex_integer_alu_top_defines.svh"

module cai_checker import cai_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [1:0]           command_i,
  input logic [PartWidth-1:0] a_re_i,
  input logic [PartWidth-1:0] a_im_i,
  input logic [PartWidth-1:0] b_re_i,
  input logic [PartWidth-1:0] b_im_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ResWidth-1:0]  res_re_o,
  input logic [ResWidth-1:0]  res_im_o,
  input logic                 div_zero_o
);

  // A stalled result beat holds.
  `CAI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(res_re_o) && $stable(res_im_o) && $stable(div_zero_o),
    "result beat changed while stalled")

  // Input back-pressure only arises from a stalled full output.
  `CAI_ASSERT(a_stall_src, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output stall")

  // A divide-by-zero result carries zero parts.
  `CAI_ASSERT(a_dz_zero, out_valid_o && div_zero_o, res_re_o == '0 && res_im_o == '0, "divide-by-zero beat with non-zero parts")

  // An offered operand beat that is not taken stays offered and unchanged.
  `CAI_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o,
    in_valid_i && $stable(command_i) && $stable(a_re_i) && $stable(a_im_i)
      && $stable(b_re_i) && $stable(b_im_i),
    "operand beat changed while stalled")

endmodule

bind complex_integer_alu_top cai_checker u_cai_checker (.*);

>>> verif/tb_complex_integer_alu_top.sv
// Self-checking testbench for the complex integer ALU: directed table, then random beats.
`timescale 1ns / 1ps

module tb_complex_integer_alu_top;
  import cai_pkg::*;

  // One operand beat and one result beat.
  typedef struct {
    cai_cmd_e               cmd;
    logic [PartWidth-1:0]   a_re;
    logic [PartWidth-1:0]   a_im;
    logic [PartWidth-1:0]   b_re;
    logic [PartWidth-1:0]   b_im;
  } operands_t;

  typedef struct packed {
    logic [ResWidth-1:0] re;
    logic [ResWidth-1:0] im;
    logic                dz;
  } complex_res_t;

  // Directed row: the operands, with a typed-in result where it is obvious.
  typedef struct {
    operands_t    op;
    bit           has_res;
    complex_res_t res;
  } directed_row_t;

  localparam int NumRandom = 500;
  localparam logic [PartWidth-1:0] PMax = {1'b0, {(PartWidth-1){1'b1}}};
  localparam logic [PartWidth-1:0] PMin = {1'b1, {(PartWidth-1){1'b0}}};
  localparam logic [PartWidth-1:0] PNeg1 = '1;
  localparam logic [PartWidth-1:0] PZero = '0;
  localparam int Latency = 2 * PartWidth + 3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           command_i;
  logic [PartWidth-1:0] a_re_i;
  logic [PartWidth-1:0] a_im_i;
  logic [PartWidth-1:0] b_re_i;
  logic [PartWidth-1:0] b_im_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ResWidth-1:0]  res_re_o;
  logic [ResWidth-1:0]  res_im_o;
  logic                 div_zero_o;

  complex_res_t pending_results[$];
  int  error_count;
  bit  hold_sink;

  complex_integer_alu_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i,
    .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .out_valid_o, .out_ready_i, .res_re_o, .res_im_o, .div_zero_o
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamp an exact value into the signed result field.
  function automatic logic [ResWidth-1:0] clamp_part(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[ResWidth-1:0];
  endfunction

  // Exact complex arithmetic on one beat; SV division truncates toward zero.
  function automatic complex_res_t complex_result(operands_t op);
    complex_res_t r;
    longint ar, ai, br, bi, den, re, im;
    ar = longint'($signed(op.a_re));
    ai = longint'($signed(op.a_im));
    br = longint'($signed(op.b_re));
    bi = longint'($signed(op.b_im));
    re = 0;
    im = 0;
    r.dz = 1'b0;
    case (op.cmd)
      CmdAdd: begin
        re = ar + br;
        im = ai + bi;
      end
      CmdSub: begin
        re = ar - br;
        im = ai - bi;
      end
      CmdMul: begin
        re = ar * br - ai * bi;
        im = ar * bi + ai * br;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          re = (ar * br + ai * bi) / den;
          im = (ai * br - ar * bi) / den;
        end
      end
    endcase
    r.re = clamp_part(re);
    r.im = clamp_part(im);
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [PartWidth-1:0] rand_part();
    case ($urandom_range(0, 7))
      0: return PMax;
      1: return PMin;
      2: return PZero;
      3: return logic'($urandom_range(0, 1)) ? PartWidth'(1) : PNeg1;
      4: return PartWidth'($urandom_range(0, 15)) - PartWidth'(8);
      default: return PartWidth'($urandom);
    endcase
  endfunction

  function automatic operands_t rand_operands();
    operands_t op;
    op.cmd  = cai_cmd_e'($urandom_range(0, 3));
    op.a_re = rand_part();
    op.a_im = rand_part();
    op.b_re = rand_part();
    op.b_im = rand_part();
    // Exercise divide by zero now and then.
    if (op.cmd == CmdDiv && $urandom_range(0, 9) == 0) begin
      op.b_re = '0;
      op.b_im = '0;
    end
    return op;
  endfunction

  // Offer one beat from the falling edge and hold it until accepted.
  task automatic send_beat(operands_t op);
    command_i  <= op.cmd;
    a_re_i     <= op.a_re;
    a_im_i     <= op.a_im;
    b_re_i     <= op.b_re;
    b_im_i     <= op.b_im;
    in_valid_i <= 1'b1;
    pending_results.push_back(complex_result(op));
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Stimulus process.
  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    operands_t op;
    int waited;
    error_count   = 0;
    hold_sink     = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = CmdAdd;
    a_re_i      = '0;
    a_im_i      = '0;
    b_re_i      = '0;
    b_im_i      = '0;

    // Directed table: extremes, every command, divide by zero, saturation.
    rows = '{
      '{'{CmdAdd, PZero, PZero, PZero, PZero}, 1, '{32'd0, 32'd0, 1'b0}},
      '{'{CmdAdd, PMax, PMax, PMax, PMax}, 1, '{32'd65534, 32'd65534, 1'b0}},
      '{'{CmdAdd, PMin, PMin, PMin, PMin}, 1, '{-32'sd65536, -32'sd65536, 1'b0}},
      '{'{CmdSub, PMax, PMin, PMin, PMax}, 1, '{32'd65535, -32'sd65535, 1'b0}},
      '{'{CmdSub, PMin, PMax, PMax, PMin}, 0, '{0, 0, 0}},
      '{'{CmdMul, PMin, PMin, PMin, PMin}, 1, '{32'd0, 32'h7fff_ffff, 1'b0}},
      '{'{CmdMul, PMax, PMax, PMax, PMax}, 0, '{0, 0, 0}},
      '{'{CmdMul, PMax, PMin, PMin, PMax}, 0, '{0, 0, 0}},
      '{'{CmdMul, PMin, PMax, PMax, PMin}, 0, '{0, 0, 0}},
      '{'{CmdMul, PNeg1, PZero, PZero, PNeg1}, 1, '{32'd0, 32'd1, 1'b0}},
      '{'{CmdDiv, PMax, PMin, PZero, PZero}, 1, '{32'd0, 32'd0, 1'b1}},
      '{'{CmdDiv, PZero, PZero, PZero, PZero}, 1, '{32'd0, 32'd0, 1'b1}},
      '{'{CmdDiv, PMin, PMin, PMin, PMin}, 1, '{32'd1, 32'd0, 1'b0}},
      '{'{CmdDiv, PMax, PMax, 16'd1, PZero}, 1, '{32'd32767, 32'd32767, 1'b0}},
      '{'{CmdDiv, PMin, PMax, PNeg1, PZero}, 0, '{0, 0, 0}},
      '{'{CmdDiv, PMin, PMin, PZero, PNeg1}, 0, '{0, 0, 0}},
      '{'{CmdDiv, 16'd7, -16'sd7, 16'd2, PZero}, 1, '{32'd3, -32'sd3, 1'b0}},
      '{'{CmdDiv, 16'd1, PZero, PMax, PMax}, 0, '{0, 0, 0}},
      '{'{CmdDiv, PMax, PMin, PMax, PMin}, 0, '{0, 0, 0}},
      '{'{CmdDiv, PMin, PMax, PMin, PMax}, 0, '{0, 0, 0}}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_res && complex_result(row.op) != row.res) begin
        $error("row %0d: typed-in result disagrees with the predictor", i);
        error_count++;
      end
      send_beat(row.op);
    end

    // Sender pauses until every expected result has come back.
    idle_sender(1);
    while (pending_results.size() != 0) @(negedge clk_i);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) hold_sink = 1'b1;
      // Back-to-back beats here, and around the long hold-off so the pipeline fills.
      if ((n > 60 && n < 120) ||
          (n >= NumRandom / 3 && n < NumRandom / 3 + Latency + 20)) begin
        idle_sender(0);
      end else begin
        idle_sender(gap_cycles());
      end
      op = rand_operands();
      send_beat(op);
    end
    in_valid_i <= 1'b0;

    // Drain, then allow the pipeline latency.
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (Latency + 10) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_complex_integer_alu_top: clean");
    end else begin
      $display("tb_complex_integer_alu_top: errors");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off counted here.
  initial begin
    int n;
    int held;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        out_ready_i <= 1'b0;
        held = 0;
        while (held < 3 * Latency) begin
          @(negedge clk_i);
          held++;
        end
        hold_sink = 1'b0;
      end
      n = gap_cycles();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk_i) begin
    complex_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_re_o !== want.re) begin
          $error("res_re: expected %0d, got %0d", $signed(want.re), $signed(res_re_o));
          error_count++;
        end
        if (res_im_o !== want.im) begin
          $error("res_im: expected %0d, got %0d", $signed(want.im), $signed(res_im_o));
          error_count++;
        end
        if (div_zero_o !== want.dz) begin
          $error("div_zero: expected %0b, got %0b", want.dz, div_zero_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #(5_000_000);
    $display("tb_complex_integer_alu_top: errors");
    $finish;
  end

endmodule
